### design/evad_pkg.sv
// Shared types and constants for the energy voice activity detector.
// Holds register reset values, register index codes and the config bundle.
// No dependencies.
package evad_pkg;

    localparam int unsigned ADDR_W    = 5;
    localparam int unsigned DATA_W    = 32;
    localparam int unsigned AMP_W     = 16;
    localparam int unsigned THR_W     = 19;
    localparam int unsigned LOUD_W    = 4;
    localparam int unsigned QUIET_W   = 3;
    localparam int unsigned AVG_SHIFT = 6;   // floor update is a running average that weights each new sample by 1/64

    localparam logic [2:0]  RST_FLOOR_GAIN    = 3'd3;
    localparam logic [11:0] RST_THRESH_OFFSET = 12'd250;
    localparam logic [15:0] RST_THRESH_MIN    = 16'd650;
    localparam logic [3:0]  RST_ONSET_COUNT   = 4'd8;
    localparam logic [2:0]  RST_RELEASE_COUNT = 3'd6;
    localparam logic [15:0] RST_FLOOR_START   = 16'd100;

    typedef enum logic [2:0] {
        REG_FLOOR_GAIN    = 3'd0,
        REG_THRESH_OFFSET = 3'd1,
        REG_THRESH_MIN    = 3'd2,
        REG_ONSET_COUNT   = 3'd3,
        REG_RELEASE_COUNT = 3'd4,
        REG_FLOOR_START   = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic [2:0]  floor_gain;
        logic [11:0] threshold_offset;
        logic [15:0] threshold_min;
        logic [3:0]  onset_count;
        logic [2:0]  release_count;
        logic [15:0] floor_start;
    } t_cfg;

endpackage

### design/evad_regs.sv
// APB-style configuration register file for the voice activity detector.
// Depends on evad_pkg for the register codes, reset values and t_cfg.
module evad_regs
    import evad_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg     r_cfg;
    t_cfg     n_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign w_wr   = psel & penable & pwrite & pready;

    always_comb begin
        n_cfg = r_cfg;
        if (w_wr) begin
            unique case (w_idx)
                REG_FLOOR_GAIN:    n_cfg.floor_gain       = pwdata[2:0];
                REG_THRESH_OFFSET: n_cfg.threshold_offset = pwdata[11:0];
                REG_THRESH_MIN:    n_cfg.threshold_min    = pwdata[15:0];
                REG_ONSET_COUNT:   n_cfg.onset_count      = pwdata[3:0];
                REG_RELEASE_COUNT: n_cfg.release_count    = pwdata[2:0];
                REG_FLOOR_START:   n_cfg.floor_start      = pwdata[15:0];
                default:           n_cfg                  = r_cfg;  // drop unmapped writes
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_FLOOR_GAIN:    prdata = {29'd0, r_cfg.floor_gain};
            REG_THRESH_OFFSET: prdata = {20'd0, r_cfg.threshold_offset};
            REG_THRESH_MIN:    prdata = {16'd0, r_cfg.threshold_min};
            REG_ONSET_COUNT:   prdata = {28'd0, r_cfg.onset_count};
            REG_RELEASE_COUNT: prdata = {29'd0, r_cfg.release_count};
            REG_FLOOR_START:   prdata = {16'd0, r_cfg.floor_start};
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.floor_gain       <= RST_FLOOR_GAIN;
            r_cfg.threshold_offset <= RST_THRESH_OFFSET;
            r_cfg.threshold_min    <= RST_THRESH_MIN;
            r_cfg.onset_count      <= RST_ONSET_COUNT;
            r_cfg.release_count    <= RST_RELEASE_COUNT;
            r_cfg.floor_start      <= RST_FLOOR_START;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

### design/energy_voice_activity_detector_top.sv
// Top level of the energy voice activity detector with adaptive noise floor.
// Depends on evad_pkg and evad_regs.
//
//   channel   direction  handshake                    payload
//   -------   ---------  ---------------------------  -------------------------------------
//   sample    in         i_valid / o_ready            i_amplitude
//   result    out        o_valid / i_ready            o_voice_active, o_noise_floor,
//                                                     o_threshold
//   config    in         psel, penable, pwrite/pready paddr, pwdata, prdata
//
// Each sample passes through two registers on its way to a result: the input register,
// then the threshold/floor logic into the result register. A new sample is taken every
// cycle while the result is not stalled; the throughput is set by the state update loop
// (floor, run counters, activity flag) that each sample closes before the next.
// Reset (synchronous, active low) clears the valid flags of both stages, all detector
// state and the registers to their defaults. A stalled result holds; the input register
// advances into the result register as soon as the result is taken, so o_ready stays high
// while the result register is empty or draining.
module energy_voice_activity_detector_top
    import evad_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // sample input
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [AMP_W-1:0]  i_amplitude,
    // result output
    output logic              o_valid,
    input  logic              i_ready,
    output logic              o_voice_active,
    output logic [15:0]       o_noise_floor,
    output logic [THR_W-1:0]  o_threshold,
    // configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    t_cfg w_cfg;

    evad_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Pipeline control
    logic               r_in_valid;
    logic [AMP_W-1:0]   r_amp;
    logic               r_out_valid;
    logic               w_out_adv;   // result register can load this cycle
    logic               w_fire;      // input register moves into the result register

    assign w_out_adv = !r_out_valid || i_ready;
    assign w_fire    = r_in_valid && w_out_adv;
    assign o_ready   = !r_in_valid || w_out_adv;

    // Detector state
    logic [15:0]        r_floor;
    logic [LOUD_W-1:0]  r_loud_run;
    logic [QUIET_W-1:0] r_quiet_run;
    logic               r_active;

    logic [15:0]        n_floor;
    logic [LOUD_W-1:0]  n_loud_run;
    logic [QUIET_W-1:0] n_quiet_run;
    logic               n_active;

    logic [15:0]        w_floor_eff;
    logic [THR_W-1:0]   w_thr_sum;
    logic [THR_W-1:0]   w_thr;
    logic               w_loud;
    logic [21:0]        w_avg_acc;

    always_comb begin
        // A zero floor restarts from the programmed start value.
        w_floor_eff = (r_floor == '0) ? w_cfg.floor_start : r_floor;
        // Threshold: floor * gain + offset, clamped from below; max fits 19 bits.
        w_thr_sum = THR_W'(w_floor_eff) * THR_W'(w_cfg.floor_gain)
                  + THR_W'(w_cfg.threshold_offset);
        w_thr     = (w_thr_sum < THR_W'(w_cfg.threshold_min))
                  ? THR_W'(w_cfg.threshold_min) : w_thr_sum;
        w_loud    = THR_W'(r_amp) > w_thr;
        // floor*63 + amp, written as floor*64 - floor + amp
        w_avg_acc = {w_floor_eff, 6'd0} - 22'(w_floor_eff) + 22'(r_amp);

        n_loud_run  = r_loud_run;
        n_quiet_run = r_quiet_run;
        n_active    = r_active;
        n_floor     = w_floor_eff;
        if (w_loud) begin
            n_quiet_run = '0;
            // Hold a run already at or past the onset count.
            if (r_loud_run < w_cfg.onset_count) begin
                n_loud_run = r_loud_run + LOUD_W'(1);
            end
            if (n_loud_run >= w_cfg.onset_count) begin
                n_active = 1'b1;
            end
        end else begin
            n_loud_run = '0;
            if (r_quiet_run < w_cfg.release_count) begin
                n_quiet_run = r_quiet_run + QUIET_W'(1);
            end
            if (n_quiet_run >= w_cfg.release_count) begin
                n_active = 1'b0;
            end
            // Quiet samples pull the floor toward the amplitude.
            n_floor = w_avg_acc[AVG_SHIFT +: 16];
        end
    end

    // Control and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_floor     <= '0;
            r_loud_run  <= '0;
            r_quiet_run <= '0;
            r_active    <= 1'b0;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (w_out_adv) begin
                r_out_valid <= r_in_valid;
            end
            if (w_fire) begin
                r_floor     <= n_floor;
                r_loud_run  <= n_loud_run;
                r_quiet_run <= n_quiet_run;
                r_active    <= n_active;
            end
        end
    end

    // Payload registers
    logic               r_res_active;
    logic [15:0]        r_res_floor;
    logic [THR_W-1:0]   r_res_thr;

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_amp <= i_amplitude;
        end
        if (w_fire) begin
            r_res_active <= n_active;
            r_res_floor  <= n_floor;
            r_res_thr    <= w_thr;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_voice_active = r_res_active;
    assign o_noise_floor  = r_res_floor;
    assign o_threshold    = r_res_thr;

endmodule

### design/evad_chk.sv
// Port-level checker for the voice activity detector, bound to the top level.
// Depends on evad_pkg for widths.
module evad_chk
    import evad_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_ready,
    input logic              o_valid,
    input logic              i_ready,
    input logic              o_voice_active,
    input logic [15:0]       o_noise_floor,
    input logic [THR_W-1:0]  o_threshold,
    input logic              pready
);

    // Largest reachable threshold: full floor times max gain plus max offset.
    localparam logic [THR_W-1:0] THR_MAX = THR_W'(65535 * 7 + 4095);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input stalled while result register is empty");

    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_voice_active)
            && $stable(o_noise_floor) && $stable(o_threshold))
        else $error("stalled result changed");

    a_thr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_threshold <= THR_MAX)
        else $error("threshold beyond reachable range");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("config port not ready");

endmodule

bind energy_voice_activity_detector_top evad_chk u_evad_chk (.*);

### tb/testbench.sv
// Self-checking bench for energy_voice_activity_detector_top: directed table, then random phases.
// Predicts results unless typed in; writes and reads back the APB registers between phases.
// Depends on evad_pkg and the detector top level.
module testbench;
    import evad_pkg::*;

    localparam int unsigned STALL_LIMIT   = 5000;
    localparam int unsigned TAIL_CYCLES   = 10;
    localparam int unsigned PHASES        = 12;
    localparam int unsigned PHASE_SAMPLES = 146;
    localparam int unsigned AMP_MAX       = (1 << AMP_W) - 1;
    localparam int unsigned REG_COUNT     = 6;
    localparam logic [2:0]  REG_SPARE     = 3'd6;  // first index past the register file
    localparam logic [2:0]  REG_NONE      = 3'd0;  // don't care on sample rows
    localparam int unsigned DIR_ROWS      = 24;

    typedef struct packed {
        logic             voice_active;
        logic [15:0]      noise_floor;
        logic [THR_W-1:0] threshold;
    } t_vad_out;

    typedef enum bit {ROW_SAMPLE, ROW_WRITE} t_row_kind;

    typedef struct packed {
        t_row_kind         kind;
        logic [2:0]        reg_sel;
        logic [DATA_W-1:0] wdata;
        logic [AMP_W-1:0]  amp;
        bit                known;
        t_vad_out          exp_out;
    } t_row;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              o_ready;
    logic [AMP_W-1:0]  i_amplitude = '0;
    logic              o_valid;
    logic              i_ready = 1'b0;
    logic              o_voice_active;
    logic [15:0]       o_noise_floor;
    logic [THR_W-1:0]  o_threshold;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    energy_voice_activity_detector_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_amplitude    (i_amplitude),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_voice_active (o_voice_active),
        .o_noise_floor  (o_noise_floor),
        .o_threshold    (o_threshold),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Detector model: register copy and state, reset values as after i_rst_n.
    t_cfg        cfg_q = '{RST_FLOOR_GAIN, RST_THRESH_OFFSET, RST_THRESH_MIN,
                           RST_ONSET_COUNT, RST_RELEASE_COUNT, RST_FLOOR_START};
    logic [15:0]        floor_q  = '0;
    logic [LOUD_W-1:0]  loud_q   = '0;
    logic [QUIET_W-1:0] quiet_q  = '0;
    logic               active_q = 1'b0;

    t_vad_out    vad_expected_q [$];
    t_vad_out    oldest;
    int unsigned err_count = 0;
    int unsigned quiet_cycles = 0;
    int unsigned snd_idle = 0;
    int unsigned rcv_idle = 0;

    // Directed table: known results typed in where they read off at a glance,
    // the rest go through the model.
    t_row dir_table [DIR_ROWS] = '{
        // zero floor replaced by the start value, quiet sample pulls it down
        '{ROW_SAMPLE, REG_NONE, 32'd0, 16'd0,     1'b1, '{1'b0, 16'd98, 19'd650}},
        // full-scale sample, threshold held at the minimum
        '{ROW_SAMPLE, REG_NONE, 32'd0, 16'd65535, 1'b1, '{1'b0, 16'd98, 19'd650}},
        '{ROW_SAMPLE, REG_NONE, 32'd0, 16'd65535, 1'b0, '0},
        '{ROW_SAMPLE, REG_NONE, 32'd0, 16'd65535, 1'b0, '0},
        '{ROW_SAMPLE, REG_NONE, 32'd0, 16'd65535, 1'b0, '0},
        // lower the onset count below the running loud count
        '{ROW_WRITE,  REG_ONSET_COUNT, 32'd2, 16'd0, 1'b0, '0},
        '{ROW_SAMPLE, REG_NONE, 32'd0, 16'd65535, 1'b1, '{1'b1, 16'd98, 19'd650}},
        '{ROW_SAMPLE, REG_NONE, 32'd0, 16'd0,     1'b0, '0},
        '{ROW_SAMPLE, REG_NONE, 32'd0, 16'd0,     1'b0, '0},
        '{ROW_SAMPLE, REG_NONE, 32'd0, 16'd0,     1'b0, '0},
        // lower the release count below the running quiet count
        '{ROW_WRITE,  REG_RELEASE_COUNT, 32'd2, 16'd0, 1'b0, '0},
        '{ROW_SAMPLE, REG_NONE, 32'd0, 16'd0,     1'b0, '0},
        // zero gain: threshold is the offset alone
        '{ROW_WRITE,  REG_FLOOR_GAIN,    32'd0,    16'd0, 1'b0, '0},
        '{ROW_WRITE,  REG_THRESH_OFFSET, 32'd4095, 16'd0, 1'b0, '0},
        '{ROW_WRITE,  REG_THRESH_MIN,    32'd0,    16'd0, 1'b0, '0},
        // amplitude equal to the threshold counts as quiet
        '{ROW_SAMPLE, REG_NONE, 32'd0, 16'd4095,  1'b0, '0},
        // zero onset and release counts act at once
        '{ROW_WRITE,  REG_ONSET_COUNT,   32'd0, 16'd0, 1'b0, '0},
        '{ROW_WRITE,  REG_RELEASE_COUNT, 32'd0, 16'd0, 1'b0, '0},
        '{ROW_SAMPLE, REG_NONE, 32'd0, 16'd4096,  1'b0, '0},
        '{ROW_SAMPLE, REG_NONE, 32'd0, 16'd0,     1'b0, '0},
        // largest gain and minimum: full-scale sample stays quiet
        '{ROW_WRITE,  REG_FLOOR_GAIN, 32'd7,     16'd0, 1'b0, '0},
        '{ROW_WRITE,  REG_THRESH_MIN, 32'd65535, 16'd0, 1'b0, '0},
        '{ROW_SAMPLE, REG_NONE, 32'd0, 16'd65535, 1'b0, '0},
        '{ROW_SAMPLE, REG_NONE, 32'd0, 16'd65535, 1'b0, '0}
    };

    function automatic int unsigned threshold_of(input logic [15:0] level);
        int unsigned thr;
        thr = level * cfg_q.floor_gain + cfg_q.threshold_offset;
        if (thr < cfg_q.threshold_min)
            thr = cfg_q.threshold_min;
        return thr;
    endfunction

    // Threshold the next sample will see.
    function automatic int unsigned threshold_now();
        return threshold_of((floor_q == '0) ? cfg_q.floor_start : floor_q);
    endfunction

    // Advance the detector model by one sample.
    task automatic detect_step(input logic [AMP_W-1:0] amp, output t_vad_out res);
        int unsigned level;
        int unsigned thr;
        level = (floor_q == '0) ? cfg_q.floor_start : floor_q;
        thr   = threshold_of(level[15:0]);
        if (amp > thr) begin
            quiet_q = '0;
            if (loud_q < cfg_q.onset_count)
                loud_q = loud_q + 1'b1;
            if (loud_q >= cfg_q.onset_count)
                active_q = 1'b1;
        end else begin
            loud_q = '0;
            if (quiet_q < cfg_q.release_count)
                quiet_q = quiet_q + 1'b1;
            if (quiet_q >= cfg_q.release_count)
                active_q = 1'b0;
            level = (level * ((1 << AVG_SHIFT) - 1) + amp) >> AVG_SHIFT;
        end
        floor_q = level[15:0];
        res = '{active_q, floor_q, thr[THR_W-1:0]};
    endtask

    function automatic logic [DATA_W-1:0] reg_value(input logic [2:0] sel);
        case (sel)
            REG_FLOOR_GAIN:    return DATA_W'(cfg_q.floor_gain);
            REG_THRESH_OFFSET: return DATA_W'(cfg_q.threshold_offset);
            REG_THRESH_MIN:    return DATA_W'(cfg_q.threshold_min);
            REG_ONSET_COUNT:   return DATA_W'(cfg_q.onset_count);
            REG_RELEASE_COUNT: return DATA_W'(cfg_q.release_count);
            REG_FLOOR_START:   return DATA_W'(cfg_q.floor_start);
            default:           return '0;
        endcase
    endfunction

    // Hold valid and payload until the transfer, then log the expected result.
    task automatic send_amp(input logic [AMP_W-1:0] amp, input bit known,
                            input t_vad_out given);
        t_vad_out predicted;
        while ($urandom_range(99) < snd_idle) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_amplitude <= amp;
        do
            @(posedge i_clk);
        while (!o_ready);
        detect_step(amp, predicted);
        vad_expected_q.push_back(known ? given : predicted);
    endtask

    // Drop valid and hold until every expected result has been taken.
    task automatic wait_idle();
        i_valid <= 1'b0;
        do
            @(posedge i_clk);
        while (vad_expected_q.size() != 0);
    endtask

    task automatic reg_write(input logic [2:0] sel, input logic [DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        case (sel)
            REG_FLOOR_GAIN:    cfg_q.floor_gain       = data[2:0];
            REG_THRESH_OFFSET: cfg_q.threshold_offset = data[11:0];
            REG_THRESH_MIN:    cfg_q.threshold_min    = data[15:0];
            REG_ONSET_COUNT:   cfg_q.onset_count      = data[3:0];
            REG_RELEASE_COUNT: cfg_q.release_count    = data[2:0];
            REG_FLOOR_START:   cfg_q.floor_start      = data[15:0];
            default: ;
        endcase
    endtask

    task automatic reg_check(input logic [2:0] sel);
        logic [DATA_W-1:0] want;
        want    = reg_value(sel);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {sel, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata !== want) begin
            $display("%0t: register %0d read: expected %0h, actual %0h",
                     $time, sel, want, prdata);
            err_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Pick a register setting per phase: all zero, all full scale, or random.
    task automatic program_phase(input int unsigned k);
        logic [DATA_W-1:0] v [REG_COUNT];
        case (k % 4)
            0: begin
                foreach (v[i])
                    v[i] = '0;
            end
            1: begin
                v[REG_FLOOR_GAIN]    = 32'd7;
                v[REG_THRESH_OFFSET] = 32'd4095;
                v[REG_THRESH_MIN]    = 32'd65535;
                v[REG_ONSET_COUNT]   = 32'd15;
                v[REG_RELEASE_COUNT] = 32'd7;
                v[REG_FLOOR_START]   = 32'd65535;
            end
            default: begin
                v[REG_FLOOR_GAIN]    = $urandom_range(7);
                v[REG_THRESH_OFFSET] = $urandom_range(4095);
                v[REG_THRESH_MIN]    = ($urandom_range(3) == 0) ? $urandom_range(65535)
                                                                : $urandom_range(1500);
                v[REG_ONSET_COUNT]   = $urandom_range(15);
                v[REG_RELEASE_COUNT] = $urandom_range(7);
                v[REG_FLOOR_START]   = ($urandom_range(3) == 0) ? 0 : $urandom_range(65535);
                // junk above the field must be dropped
                foreach (v[i])
                    if ($urandom_range(1) == 1)
                        v[i][31:16] = 16'($urandom());
            end
        endcase
        foreach (v[i])
            reg_write(3'(i), v[i]);
        reg_write(REG_SPARE + 3'($urandom_range(1)), $urandom());
        foreach (v[i])
            reg_check(3'(i));
    endtask

    // Result side: stall at random, compare each transfer with the oldest expectation.
    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= rcv_idle);
        if (i_rst_n && o_valid && i_ready) begin
            if (vad_expected_q.size() == 0) begin
                $display("%0t: unexpected result: active %0d floor %0d threshold %0d",
                         $time, o_voice_active, o_noise_floor, o_threshold);
                err_count++;
            end else begin
                oldest = vad_expected_q.pop_front();
                if (o_voice_active !== oldest.voice_active) begin
                    $display("%0t: voice_active: expected %0d, actual %0d",
                             $time, oldest.voice_active, o_voice_active);
                    err_count++;
                end
                if (o_noise_floor !== oldest.noise_floor) begin
                    $display("%0t: noise_floor: expected %0d, actual %0d",
                             $time, oldest.noise_floor, o_noise_floor);
                    err_count++;
                end
                if (o_threshold !== oldest.threshold) begin
                    $display("%0t: threshold: expected %0d, actual %0d",
                             $time, oldest.threshold, o_threshold);
                    err_count++;
                end
            end
        end
    end

    // Count cycles with no transfer on any port.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready) || (psel && penable))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        wait (quiet_cycles >= STALL_LIMIT);
        $display("testbench: errors");
        $finish;
    end

    initial begin
        int unsigned sent;
        int unsigned len;
        int unsigned kind;
        int unsigned thr;
        int          near_v;
        logic [AMP_W-1:0] amp;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        snd_idle = 21;
        rcv_idle = 70;
        foreach (dir_table[r]) begin
            if (dir_table[r].kind == ROW_WRITE) begin
                wait_idle();
                reg_write(dir_table[r].reg_sel, dir_table[r].wdata);
            end else begin
                send_amp(dir_table[r].amp, dir_table[r].known, dir_table[r].exp_out);
            end
        end

        for (int unsigned k = 0; k < PHASES; k++) begin
            // swap the idling sides after a third, then run without idling
            if (k == PHASES / 3) begin
                snd_idle = 70;
                rcv_idle = 21;
            end else if (k == 2 * PHASES / 3) begin
                snd_idle = 0;
                rcv_idle = 0;
            end
            wait_idle();
            program_phase(k);
            sent = 0;
            while (sent < PHASE_SAMPLES) begin
                kind = $urandom_range(15);
                len  = (kind == 14) ? $urandom_range(120, 1) : $urandom_range(20, 1);
                if (kind == 15) begin
                    // pause the sender until the pipeline is empty
                    wait_idle();
                    continue;
                end
                for (int unsigned j = 0; j < len && sent < PHASE_SAMPLES; j++) begin
                    thr = threshold_now();
                    if (kind <= 5) begin
                        // loud run
                        amp = (thr >= AMP_MAX) ? AMP_W'($urandom())
                                               : AMP_W'($urandom_range(AMP_MAX, thr + 1));
                    end else if (kind <= 10) begin
                        // quiet run
                        amp = AMP_W'($urandom_range((thr > AMP_MAX) ? AMP_MAX : thr, 0));
                    end else if (kind <= 12) begin
                        // straddle the threshold
                        near_v = int'(thr) + int'($urandom_range(2)) - 1;
                        if (near_v < 0)
                            near_v = 0;
                        if (near_v > int'(AMP_MAX))
                            near_v = AMP_MAX;
                        amp = AMP_W'(near_v);
                    end else if (kind == 13) begin
                        amp = AMP_W'($urandom());
                    end else begin
                        // silence drains the floor toward zero
                        amp = '0;
                    end
                    send_amp(amp, 1'b0, '0);
                    sent++;
                end
            end
        end

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (err_count == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule

### energy_voice_activity_detector_top.f
design/evad_pkg.sv
design/evad_regs.sv
design/energy_voice_activity_detector_top.sv
design/evad_chk.sv
tb/testbench.sv
